### rtl/core/wps_pkg.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser package
// Shared types, operation codes and constants for the front end, the command
// queue and the result formatter.
// ----------------------------------------------------------------------------
package wps_pkg;

    // Fixed header length in bytes and the position of its final byte.
    localparam int HEADER_BYTES = 46;
    localparam logic [5:0] HDR_LAST = 6'(HEADER_BYTES - 1);

    // Default depth of the queue between the front end and the formatter.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_FRAME = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COUNT = 1'd1;

    // Result kinds.
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_TAG     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    // Operations passed from the front end to the formatter.
    localparam logic [1:0] OP_REPORT = 2'd0;  // header report
    localparam logic [1:0] OP_SAMPLE = 2'd1;  // one assembled frame
    localparam logic [1:0] OP_MARK   = 2'd2;  // short-end marker without samples

    // Input beat.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } wps_in_t;

    // Result beat.
    typedef struct packed {
        logic               kind;
        logic [1:0]         status;
        logic [15:0]        channels;
        logic [15:0]        bits;
        logic [31:0]        total_frames;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               short_end;
    } wps_out_t;

    // Configuration write as seen by the front end.
    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } wps_cfg_wr_t;

    // Command held in the queue.
    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  status;
        logic [15:0] chan;
        logic [15:0] depth;
        logic [31:0] size;
        logic [31:0] raw;
        logic        short_end;
    } wps_cmd_t;

endpackage

### rtl/core/wps_front.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser front end
// Walks the header byte by byte, checks the tags, captures the format fields,
// assembles data frames and decides which commands go to the queue.
// ----------------------------------------------------------------------------
module wps_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wps_pkg::wps_cfg_wr_t cfg_wr,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wps_pkg::wps_in_t     s_data,
    input  logic                 q_full,
    output logic                 push_valid,
    output wps_pkg::wps_cmd_t    push_cmd
);

    // Header positions of the captured fields.
    localparam logic [5:0] POS_CHAN_LO  = 6'd22;
    localparam logic [5:0] POS_CHAN_HI  = 6'd23;
    localparam logic [5:0] POS_DEPTH_LO = 6'd34;
    localparam logic [5:0] POS_DEPTH_HI = 6'd35;
    localparam logic [5:0] POS_SIZE_B0  = 6'd42;
    localparam logic [5:0] POS_SIZE_B1  = 6'd43;
    localparam logic [5:0] POS_SIZE_B2  = 6'd44;
    localparam logic [5:0] POS_SIZE_B3  = 6'd45;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } tag_t;

    // Expected tag byte at a header position, if that position holds a tag.
    function automatic tag_t expected_tag(input logic [5:0] p);
        tag_t t;
        t.hit = 1'b1;
        case (p)
            6'd0:  t.value = 8'h52;  // R
            6'd1:  t.value = 8'h49;  // I
            6'd2:  t.value = 8'h46;  // F
            6'd3:  t.value = 8'h46;  // F
            6'd8:  t.value = 8'h57;  // W
            6'd9:  t.value = 8'h41;  // A
            6'd10: t.value = 8'h56;  // V
            6'd11: t.value = 8'h45;  // E
            6'd12: t.value = 8'h66;  // f
            6'd13: t.value = 8'h6d;  // m
            6'd14: t.value = 8'h74;  // t
            6'd15: t.value = 8'h20;  // space
            6'd38: t.value = 8'h64;  // d
            6'd39: t.value = 8'h61;  // a
            6'd40: t.value = 8'h74;  // t
            6'd41: t.value = 8'h61;  // a
            default: begin
                t.hit   = 1'b0;
                t.value = 8'h00;
            end
        endcase
        return t;
    endfunction

    logic [5:0]  header_pos_reg, header_pos_next;
    logic        header_done_reg, header_done_next;
    logic        error_seen_reg, error_seen_next;
    logic [15:0] chan_reg, chan_next;
    logic [15:0] depth_reg, depth_next;
    logic [31:0] size_reg, size_next;
    logic [1:0]  fb_last_reg, fb_last_next;
    logic [1:0]  byte_in_frame_reg, byte_in_frame_next;
    logic [23:0] part_buf_reg, part_buf_next;
    logic [31:0] frames_seen_reg, frames_seen_next;
    logic [31:0] frames_given_reg, frames_given_next;
    logic [31:0] start_frame_reg, frame_count_reg;

    logic        acc;
    logic [7:0]  b;
    logic        fin;
    tag_t        tag;
    logic        err_now;
    logic [15:0] chan_now, depth_now;
    logic [31:0] size_now;
    logic [1:0]  status;
    logic [31:0] full;
    logic        want;
    logic [32:0] given_inc;
    logic        fc_set;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign b       = s_data.byte_in;
    assign fin     = s_data.last;
    assign fc_set  = frame_count_reg != 32'd0;

    // Parse, assemble and classify one accepted byte.
    always_comb begin
        header_pos_next    = header_pos_reg;
        header_done_next   = header_done_reg;
        error_seen_next    = error_seen_reg;
        chan_next          = chan_reg;
        depth_next         = depth_reg;
        size_next          = size_reg;
        fb_last_next       = fb_last_reg;
        byte_in_frame_next = byte_in_frame_reg;
        part_buf_next      = part_buf_reg;
        frames_seen_next   = frames_seen_reg;
        frames_given_next  = frames_given_reg;
        push_valid         = 1'b0;
        push_cmd           = '0;
        tag                = expected_tag(header_pos_reg);
        err_now            = error_seen_reg | (tag.hit && (tag.value != b));
        chan_now           = chan_reg;
        depth_now          = depth_reg;
        size_now           = size_reg;
        status             = wps_pkg::ST_OK;
        full = {8'h00, part_buf_reg} | ({24'h000000, b} << {byte_in_frame_reg, 3'b000});
        want = (frames_seen_reg >= start_frame_reg) &&
               (!fc_set || (frames_given_reg < frame_count_reg));
        given_inc = {1'b0, frames_given_reg} + 33'd1;

        case (header_pos_reg)
            POS_CHAN_LO:  chan_now  = {8'h00, b};
            POS_CHAN_HI:  chan_now  = {b, chan_reg[7:0]};
            POS_DEPTH_LO: depth_now = {8'h00, b};
            POS_DEPTH_HI: depth_now = {b, depth_reg[7:0]};
            POS_SIZE_B0:  size_now  = size_reg | {24'h000000, b};
            POS_SIZE_B1:  size_now  = size_reg | {16'h0000, b, 8'h00};
            POS_SIZE_B2:  size_now  = size_reg | {8'h00, b, 16'h0000};
            POS_SIZE_B3:  size_now  = size_reg | {b, 24'h000000};
            default: ;
        endcase

        if (err_now) begin
            status = wps_pkg::ST_BAD_TAG;
        end else if ((chan_now != 16'd1 && chan_now != 16'd2) ||
                     (depth_now != 16'd8 && depth_now != 16'd16)) begin
            status = wps_pkg::ST_UNSUPPORTED;
        end else begin
            status = wps_pkg::ST_OK;
        end

        if (acc) begin
            if (!header_done_reg) begin
                // Header byte.
                chan_next       = chan_now;
                depth_next      = depth_now;
                size_next       = size_now;
                error_seen_next = err_now;
                if (header_pos_reg == wps_pkg::HDR_LAST) begin
                    error_seen_next  = status != wps_pkg::ST_OK;
                    header_done_next = 1'b1;
                    if (chan_now == 16'd2) begin
                        fb_last_next = (depth_now == 16'd16) ? 2'd3 : 2'd1;
                    end else begin
                        fb_last_next = (depth_now == 16'd16) ? 2'd1 : 2'd0;
                    end
                    push_valid         = 1'b1;
                    push_cmd.op        = wps_pkg::OP_REPORT;
                    push_cmd.status    = status;
                    push_cmd.chan      = chan_now;
                    push_cmd.depth     = depth_now;
                    push_cmd.size      = size_now;
                    push_cmd.raw       = 32'd0;
                    push_cmd.short_end = fin && (status == wps_pkg::ST_OK) && fc_set;
                end else begin
                    header_pos_next = header_pos_reg + 6'd1;
                end
            end else if (!error_seen_reg) begin
                // Data byte of an accepted header.
                if (byte_in_frame_reg != fb_last_reg) begin
                    part_buf_next      = full[23:0];
                    byte_in_frame_next = byte_in_frame_reg + 2'd1;
                end else begin
                    part_buf_next      = 24'd0;
                    byte_in_frame_next = 2'd0;
                    if (frames_seen_reg != 32'hFFFF_FFFF) begin
                        frames_seen_next = frames_seen_reg + 32'd1;
                    end
                    if (want) begin
                        if (frames_given_reg != 32'hFFFF_FFFF) begin
                            frames_given_next = given_inc[31:0];
                        end
                        push_valid         = 1'b1;
                        push_cmd.op        = wps_pkg::OP_SAMPLE;
                        push_cmd.status    = wps_pkg::ST_OK;
                        push_cmd.chan      = chan_reg;
                        push_cmd.depth     = depth_reg;
                        push_cmd.size      = size_reg;
                        push_cmd.raw       = full;
                        push_cmd.short_end = fin && fc_set &&
                                             (given_inc < {1'b0, frame_count_reg});
                    end
                end
                // Stream ended early with no frame on this byte.
                if (fin && !push_valid && fc_set &&
                    (frames_given_reg < frame_count_reg)) begin
                    push_valid         = 1'b1;
                    push_cmd.op        = wps_pkg::OP_MARK;
                    push_cmd.status    = wps_pkg::ST_OK;
                    push_cmd.chan      = chan_reg;
                    push_cmd.depth     = depth_reg;
                    push_cmd.size      = size_reg;
                    push_cmd.raw       = 32'd0;
                    push_cmd.short_end = 1'b1;
                end
            end
            // The final byte returns the parser to the start of a header.
            if (fin) begin
                header_pos_next    = 6'd0;
                header_done_next   = 1'b0;
                error_seen_next    = 1'b0;
                chan_next          = 16'd0;
                depth_next         = 16'd0;
                size_next          = 32'd0;
                fb_last_next       = 2'd0;
                byte_in_frame_next = 2'd0;
                part_buf_next      = 24'd0;
                frames_seen_next   = 32'd0;
                frames_given_next  = 32'd0;
            end
        end
    end

    // Parser state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_pos_reg    <= 6'd0;
            header_done_reg   <= 1'b0;
            error_seen_reg    <= 1'b0;
            chan_reg          <= 16'd0;
            depth_reg         <= 16'd0;
            size_reg          <= 32'd0;
            fb_last_reg       <= 2'd0;
            byte_in_frame_reg <= 2'd0;
            part_buf_reg      <= 24'd0;
            frames_seen_reg   <= 32'd0;
            frames_given_reg  <= 32'd0;
        end else begin
            header_pos_reg    <= header_pos_next;
            header_done_reg   <= header_done_next;
            error_seen_reg    <= error_seen_next;
            chan_reg          <= chan_next;
            depth_reg         <= depth_next;
            size_reg          <= size_next;
            fb_last_reg       <= fb_last_next;
            byte_in_frame_reg <= byte_in_frame_next;
            part_buf_reg      <= part_buf_next;
            frames_seen_reg   <= frames_seen_next;
            frames_given_reg  <= frames_given_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_frame_reg <= 32'd0;
            frame_count_reg <= 32'd0;
        end else if (cfg_wr.valid) begin
            case (cfg_wr.index)
                wps_pkg::CFG_START_FRAME: start_frame_reg <= cfg_wr.data;
                wps_pkg::CFG_FRAME_COUNT: frame_count_reg <= cfg_wr.data;
                default: ;
            endcase
        end
    end

    // After a final byte the parser is back at the first header byte.
    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && fin) |=> (header_pos_reg == 6'd0 && !header_done_reg && !error_seen_reg))
        else $error("parser did not restart after the final byte");

endmodule

### rtl/core/wps_queue.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser command queue
// Small register FIFO between the front end and the result formatter, so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module wps_queue #(
    parameter int DEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  wps_pkg::wps_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output wps_pkg::wps_cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wps_pkg::wps_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop_fire;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_fire  = pop && pop_valid;
    assign pop_cmd   = mem_reg[rd_ptr_reg];

    // Pointer and fill-level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_valid, pop_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill level beyond its depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !full)
        else $error("command pushed into a full queue");

endmodule

### rtl/core/wps_back.sv
// ----------------------------------------------------------------------------
// WAV PCM stream parser result formatter
// Takes commands from the queue, forms Q1.15 samples and the frame total,
// and holds each result beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module wps_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    input  wps_pkg::wps_cmd_t pop_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output wps_pkg::wps_out_t m_data
);

    logic              m_valid_reg, m_valid_next;
    wps_pkg::wps_out_t out_reg, out_next;
    logic              stereo, wide;
    logic [31:0]       total;
    logic [15:0]       left, right;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pop     = pop_valid && (!m_valid_reg || m_ready);
    assign stereo  = pop_cmd.chan == 16'd2;
    assign wide    = pop_cmd.depth == 16'd16;

    // Frame total: frames are one, two or four bytes long.
    always_comb begin
        case ({stereo, wide})
            2'b00:   total = pop_cmd.size;
            2'b11:   total = pop_cmd.size >> 2;
            default: total = pop_cmd.size >> 1;
        endcase
    end

    // Sample forming: 8-bit data has its offset of 128 removed.
    always_comb begin
        if (wide) begin
            left  = pop_cmd.raw[15:0];
            right = stereo ? pop_cmd.raw[31:16] : pop_cmd.raw[15:0];
        end else begin
            left  = {pop_cmd.raw[7:0] ^ 8'h80, 8'h00};
            right = stereo ? {pop_cmd.raw[15:8] ^ 8'h80, 8'h00} : left;
        end
    end

    // Result beat assembly.
    always_comb begin
        out_next              = out_reg;
        m_valid_next          = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            m_valid_next          = 1'b1;
            out_next.status       = pop_cmd.status;
            out_next.channels     = pop_cmd.chan;
            out_next.bits         = pop_cmd.depth;
            out_next.short_end    = pop_cmd.short_end;
            out_next.total_frames = total;
            case (pop_cmd.op)
                wps_pkg::OP_REPORT: begin
                    out_next.kind  = wps_pkg::KIND_REPORT;
                    out_next.left  = 16'sd0;
                    out_next.right = 16'sd0;
                    if (pop_cmd.status != wps_pkg::ST_OK) begin
                        out_next.total_frames = 32'd0;
                    end
                end
                wps_pkg::OP_SAMPLE: begin
                    out_next.kind  = wps_pkg::KIND_SAMPLE;
                    out_next.left  = left;
                    out_next.right = right;
                end
                wps_pkg::OP_MARK: begin
                    out_next.kind  = wps_pkg::KIND_SAMPLE;
                    out_next.left  = 16'sd0;
                    out_next.right = 16'sd0;
                end
                default: begin
                    out_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    a_sample_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.kind == wps_pkg::KIND_SAMPLE) |->
            (out_reg.status == wps_pkg::ST_OK))
        else $error("sample beat with a non-ok status");

    a_rejected_no_total: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status != wps_pkg::ST_OK) |->
            (out_reg.total_frames == 32'd0 && !out_reg.short_end))
        else $error("rejected header report carries a frame total or short end");

endmodule

### rtl/core/wav_pcm_stream_parser.sv
// Path: the command for an accepted input beat is written into the command queue, and the
// result beat is then registered in the output register that drives m_data.
// Throughput: one byte per cycle; a result beat waiting at m_data does not block input
// until the command queue (QUEUE_DEPTH entries) is full.
// Reset: aresetn is synchronous and active low; it clears the parser, the queue,
// the output valid flag and both configuration registers.
// ----------------------------------------------------------------------------
// WAV PCM stream parser
// Parses a byte-wide WAV stream, reports the header once and gives signed
// Q1.15 left/right frames, with frame skipping and a frame limit.
// ----------------------------------------------------------------------------
module wav_pcm_stream_parser #(
    parameter int QUEUE_DEPTH = wps_pkg::QUEUE_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [wps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  wps_pkg::wps_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output wps_pkg::wps_out_t                  m_data
);

    wps_pkg::wps_cfg_wr_t cfg_wr;
    logic                 q_full;
    logic                 push_valid;
    wps_pkg::wps_cmd_t    push_cmd;
    logic                 pop;
    logic                 pop_valid;
    wps_pkg::wps_cmd_t    pop_cmd;

    // Configuration writes are always taken.
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    wps_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr     (cfg_wr),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    wps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    wps_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
